### sv/scq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_pkg: shared definitions for the stack/queue trace checker
// sizes, request and command codes, and the command and result records
// ----------------------------------------------------------------------------
package scq_pkg;

   // storage sizes
   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int VALUE_W    = 32;
   localparam int STORE_W    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;

   // two-slot queues between the parts
   localparam int QUEUE_SLOTS = 2;
   localparam int QCNT_W      = 2;

   // request modes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // internal command codes
   typedef logic [1:0] op_type;
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_CLEAR  = 2'd2;
   localparam op_type OP_NOP    = 2'd3;

   // verdict codes
   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_BOTH    = 2'd0;
   localparam verdict_type VERDICT_STACK   = 2'd1;
   localparam verdict_type VERDICT_QUEUE   = 2'd2;
   localparam verdict_type VERDICT_NEITHER = 2'd3;

   typedef struct packed {
      op_type             op;
      logic [STORE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic        stack_match;
      logic        queue_match;
      verdict_type verdict;
      logic        capacity_fault;
   } rsp_type;

   function automatic verdict_type verdict_of(input logic lifo_ok, input logic fifo_ok);
      verdict_type v;
      begin
         if (lifo_ok && fifo_ok) begin
            v = VERDICT_BOTH;
         end else if (lifo_ok) begin
            v = VERDICT_STACK;
         end else if (fifo_ok) begin
            v = VERDICT_QUEUE;
         end else begin
            v = VERDICT_NEITHER;
         end
         return v;
      end
   endfunction

endpackage

### sv/stack_queue_trace_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_trace_checker_top: LIFO/FIFO trace checker
// checks a trace of insert and remove requests against stack and queue order
// ----------------------------------------------------------------------------
// Every request yields exactly one result. An insert or clear request, and a
// remove on an empty store, needs a single pass through the execution unit,
// so these run at one request per cycle while the result queue has room; a
// remove with data also passes the compare state, because both stores are
// synchronous memories whose read data is registered before the compare. A
// request is registered in the command queue and its result in the result queue
// before it shows on the rsp_ ports. A two-slot command queue sits between
// intake and execution and a two-slot result queue after it, so a stalled rsp_
// side still lets requests in until the queues fill. Stores hold 1024 entries;
// an insert on full is dropped and flagged, a remove on empty clears both match
// flags. No start-up clearing is needed: only written entries are ever read.
// ----------------------------------------------------------------------------
module stack_queue_trace_checker_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [scq_pkg::MODE_W-1:0]            req_mode,
   input  logic signed [scq_pkg::VALUE_W-1:0]    req_value,
   // result side
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic                                  rsp_stack_match,
   output logic                                  rsp_queue_match,
   output logic [1:0]                            rsp_verdict,
   output logic                                  rsp_capacity_fault
);

   // command channel between intake and execution
   logic              cmd_valid;
   logic              cmd_pop;
   scq_pkg::cmd_type  cmd;
   scq_pkg::rsp_type  rsp;

   // intake: classify the request and queue it
   scq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_mode  (req_mode),
      .req_value (req_value),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // execution: stores, match flags and result queue
   scq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   // unpack the head result
   assign rsp_stack_match    = rsp.stack_match;
   assign rsp_queue_match    = rsp.queue_match;
   assign rsp_verdict        = rsp.verdict;
   assign rsp_capacity_fault = rsp.capacity_fault;

   // execution never takes a command that is not there
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty command queue");

   // a request that is taken is visible to execution on the next cycle
   a_request_reaches_back: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> cmd_valid)
      else $error("accepted request missing from command queue");

   // commands other than a remove leave a result in the result queue at once
   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && (cmd.op != scq_pkg::OP_REMOVE)) |=> !rsp_empty)
      else $error("no result after single-cycle command");

endmodule

### sv/scq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_front: request intake
// classifies each request into a command and holds it in a two-slot queue
// ----------------------------------------------------------------------------
module scq_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  logic [scq_pkg::MODE_W-1:0]            req_mode,
   input  logic signed [scq_pkg::VALUE_W-1:0]    req_value,
   output logic                                  req_full,
   output logic                                  cmd_valid,
   output scq_pkg::cmd_type                      cmd,
   input  logic                                  cmd_pop
);

   scq_pkg::cmd_type                 slot_ff [scq_pkg::QUEUE_SLOTS];
   scq_pkg::cmd_type                 new_cmd;
   logic                             wr_ptr_ff, wr_ptr_in;
   logic                             rd_ptr_ff, rd_ptr_in;
   logic [scq_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             push_ok;
   logic                             pop_ok;

   // classify
   always_comb begin
      case (req_mode)
         scq_pkg::MODE_INSERT: new_cmd.op = scq_pkg::OP_INSERT;
         scq_pkg::MODE_REMOVE: new_cmd.op = scq_pkg::OP_REMOVE;
         scq_pkg::MODE_CLEAR:  new_cmd.op = scq_pkg::OP_CLEAR;
         default:              new_cmd.op = scq_pkg::OP_NOP;
      endcase
      new_cmd.data = req_value[scq_pkg::STORE_W-1:0];
   end

   assign req_full  = (count_ff == scq_pkg::QCNT_W'(scq_pkg::QUEUE_SLOTS));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push & ~req_full;
   assign pop_ok    = cmd_pop & cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + scq_pkg::QCNT_W'(push_ok) - scq_pkg::QCNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### sv/scq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_back: command execution
// runs commands against the stack and ring-buffer stores, keeps the match
// flags and queues the results in a two-slot output queue
// ----------------------------------------------------------------------------
module scq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  scq_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output scq_pkg::rsp_type  rsp
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CMP  = 1'b1;

   logic                           state_ff, state_in;
   // both stores always hold the same number of entries, so one count serves
   logic [scq_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [scq_pkg::ADDR_W-1:0]     head_ff, head_in;
   logic                           lifo_ok_ff, lifo_ok_in;
   logic                           fifo_ok_ff, fifo_ok_in;
   logic [scq_pkg::STORE_W-1:0]    data_ff, data_in;

   logic [scq_pkg::STORE_W-1:0]    lifo_mem [scq_pkg::DEPTH];
   logic [scq_pkg::STORE_W-1:0]    fifo_mem [scq_pkg::DEPTH];
   logic [scq_pkg::STORE_W-1:0]    lifo_rd_ff;
   logic [scq_pkg::STORE_W-1:0]    fifo_rd_ff;

   logic                           mem_we;
   logic                           mem_re;
   logic [scq_pkg::CNT_W-1:0]      cnt_dec;
   logic [scq_pkg::SUM_W-1:0]      tail_sum;
   logic [scq_pkg::SUM_W-1:0]      tail_wrap;
   logic [scq_pkg::ADDR_W-1:0]     tail;
   logic [scq_pkg::ADDR_W-1:0]     head_inc;
   logic [scq_pkg::ADDR_W-1:0]     lifo_waddr;
   logic [scq_pkg::ADDR_W-1:0]     lifo_raddr;
   logic                           at_full;
   logic                           fault;

   scq_pkg::rsp_type               res;
   logic                           res_push;
   scq_pkg::rsp_type               rq_slot_ff [scq_pkg::QUEUE_SLOTS];
   logic                           rq_wr_ff, rq_wr_in;
   logic                           rq_rd_ff, rq_rd_in;
   logic [scq_pkg::QCNT_W-1:0]     rq_count_ff, rq_count_in;
   logic                           rq_full;
   logic                           rq_pop;

   // address arithmetic
   always_comb begin
      cnt_dec    = count_ff - 1'b1;
      tail_sum   = scq_pkg::SUM_W'(head_ff) + scq_pkg::SUM_W'(count_ff);
      tail_wrap  = (tail_sum >= scq_pkg::SUM_W'(scq_pkg::DEPTH))
                   ? tail_sum - scq_pkg::SUM_W'(scq_pkg::DEPTH) : tail_sum;
      tail       = tail_wrap[scq_pkg::ADDR_W-1:0];
      head_inc   = (head_ff == scq_pkg::ADDR_W'(scq_pkg::DEPTH - 1))
                   ? '0 : head_ff + 1'b1;
      lifo_waddr = count_ff[scq_pkg::ADDR_W-1:0];
      lifo_raddr = cnt_dec[scq_pkg::ADDR_W-1:0];
      at_full    = (count_ff >= scq_pkg::CNT_W'(scq_pkg::DEPTH));
   end

   assign rq_full = (rq_count_ff == scq_pkg::QCNT_W'(scq_pkg::QUEUE_SLOTS));

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      lifo_ok_in = lifo_ok_ff;
      fifo_ok_in = fifo_ok_ff;
      data_in    = data_ff;
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      res_push   = 1'b0;
      fault      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rq_full) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  scq_pkg::OP_INSERT: begin
                     res_push = 1'b1;
                     if (at_full) begin
                        fault = 1'b1;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  scq_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        lifo_ok_in = 1'b0;
                        fifo_ok_in = 1'b0;
                        res_push   = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        count_in = cnt_dec;
                        head_in  = head_inc;
                        data_in  = cmd.data;
                        state_in = ST_CMP;
                     end
                  end
                  scq_pkg::OP_CLEAR: begin
                     count_in   = '0;
                     head_in    = '0;
                     lifo_ok_in = 1'b1;
                     fifo_ok_in = 1'b1;
                     res_push   = 1'b1;
                  end
                  default: begin
                     res_push = 1'b1;
                  end
               endcase
            end
         end
         ST_CMP: begin
            // compare popped and dequeued entries with the expected value
            lifo_ok_in = lifo_ok_ff & (lifo_rd_ff == data_ff);
            fifo_ok_in = fifo_ok_ff & (fifo_rd_ff == data_ff);
            res_push   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      res.stack_match    = lifo_ok_in;
      res.queue_match    = fifo_ok_in;
      res.verdict        = scq_pkg::verdict_of(lifo_ok_in, fifo_ok_in);
      res.capacity_fault = fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         head_ff    <= '0;
         lifo_ok_ff <= 1'b1;
         fifo_ok_ff <= 1'b1;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         head_ff    <= head_in;
         lifo_ok_ff <= lifo_ok_in;
         fifo_ok_ff <= fifo_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // stack store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lifo_mem[lifo_waddr] <= cmd.data;
      end
      if (mem_re) begin
         lifo_rd_ff <= lifo_mem[lifo_raddr];
      end
   end

   // ring-buffer store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fifo_mem[tail] <= cmd.data;
      end
      if (mem_re) begin
         fifo_rd_ff <= fifo_mem[head_ff];
      end
   end

   // result queue
   assign rsp_empty = (rq_count_ff == '0);
   assign rsp       = rq_slot_ff[rq_rd_ff];
   assign rq_pop    = rsp_pop & ~rsp_empty;

   always_comb begin
      rq_wr_in    = res_push ? ~rq_wr_ff : rq_wr_ff;
      rq_rd_in    = rq_pop ? ~rq_rd_ff : rq_rd_ff;
      rq_count_in = rq_count_ff + scq_pkg::QCNT_W'(res_push) - scq_pkg::QCNT_W'(rq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_slot_ff[rq_wr_ff] <= res;
      end
   end

endmodule

### sim/tb_stack_queue_trace_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_queue_trace_checker_top: self-checking bench for the trace checker
// drives insert, remove, new-case and unused-mode requests through the queue-style ports,
// predicts the stack/queue match flags, verdict and capacity fault of every
// request, and checks each result popped from the rsp_ side in order
// ----------------------------------------------------------------------------
module tb_stack_queue_trace_checker_top;

   import scq_pkg::*;

   // mode 3 has no meaning to the block, it only reports the flags
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_REQUESTS = 300;
   localparam int STALL_LIMIT     = 2000;   // cycles with no handshake on either side
   localparam int DRAIN_CYCLES    = 8;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
   } trace_event_type;

   // dut ports, inputs all known from time zero
   logic                      clock              = 1'b0;
   logic                      reset              = 1'b1;
   logic                      req_push           = 1'b0;
   logic                      req_full;
   logic [MODE_W-1:0]         req_mode           = MODE_CLEAR;
   logic signed [VALUE_W-1:0] req_value          = '0;
   logic                      rsp_empty;
   logic                      rsp_pop            = 1'b0;
   logic                      rsp_stack_match;
   logic                      rsp_queue_match;
   logic [1:0]                rsp_verdict;
   logic                      rsp_capacity_fault;

   // requests still to be sent, filled once before reset is released
   trace_event_type trace_backlog[$];
   int              random_sent;

   // shadow of the block: stack, ring buffer and both match flags
   logic [STORE_W-1:0] stack_mem [DEPTH];
   logic [CNT_W-1:0]   stack_depth;
   logic [STORE_W-1:0] ring_mem [DEPTH];
   logic [ADDR_W-1:0]  ring_head;
   logic [CNT_W-1:0]   ring_depth;
   logic               stack_ok;
   logic               ring_ok;

   // flag reports owed by the block, oldest first
   rsp_type flag_reports_due[$];

   int mismatch_count;
   int quiet_cycles;
   int send_wait, send_calm;
   int take_wait, take_calm;

   stack_queue_trace_checker_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_value          (req_value),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_stack_match    (rsp_stack_match),
      .rsp_queue_match    (rsp_queue_match),
      .rsp_verdict        (rsp_verdict),
      .rsp_capacity_fault (rsp_capacity_fault)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   task automatic add_event(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
      trace_event_type ev;
      ev.mode  = mode;
      ev.value = value;
      trace_backlog.push_back(ev);
   endtask

   // random gap per request, with the odd stretch of no idling
   task automatic draw_gap(inout int calm, output int gap);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         gap  = 0;
      end else begin
         gap = $urandom_range(0, 5);
      end
   endtask

   // values drawn from a tiny range now and then, so that wrong orders can still agree
   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) begin
         return VALUE_W'($urandom_range(0, 3));
      end
      return $urandom;
   endfunction

   // one well-formed case: new case, then rounds of inserts and removes whose
   // expected values follow stack order, queue order, or neither
   task automatic add_case();
      logic [VALUE_W-1:0] held[$];
      logic [VALUE_W-1:0] v;
      int order_style;
      int rounds, inserts, removes;
      order_style = $urandom_range(0, 3);
      rounds      = $urandom_range(1, 3);
      add_event(MODE_CLEAR, $urandom);
      random_sent++;
      for (int r = 0; r < rounds; r++) begin
         inserts = $urandom_range(0, 8);
         for (int i = 0; i < inserts; i++) begin
            v = pick_value();
            held.push_back(v);
            add_event(MODE_INSERT, v);
            random_sent++;
         end
         removes = $urandom_range(0, held.size());
         // now and then one remove too many, so the stores run dry
         if ($urandom_range(0, 7) == 0) begin
            removes = held.size() + 1;
         end
         for (int i = 0; i < removes; i++) begin
            if (held.size() == 0) begin
               v = pick_value();
            end else begin
               case (order_style)
                  0: v = held.pop_back();
                  1: v = held.pop_front();
                  2: begin
                     v = ($urandom_range(0, 1) != 0) ? held.pop_back() : held.pop_front();
                     if ($urandom_range(0, 5) == 0) begin
                        v[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
                     end
                  end
                  default: begin
                     void'(held.pop_front());
                     v = pick_value();
                  end
               endcase
            end
            add_event(MODE_REMOVE, v);
            random_sent++;
         end
      end
   endtask

   // unstructured requests of any mode
   task automatic add_noise();
      int n;
      logic [MODE_W-1:0] mode;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         mode = MODE_W'($urandom_range(0, 3));
         add_event(mode, $urandom);
         if (mode != MODE_UNUSED) begin
            random_sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // predictor: applies one request to the shadow and queues its flag report
   // ------------------------------------------------------------------------
   task automatic classify_request(input logic [MODE_W-1:0]  mode,
                                   input logic [VALUE_W-1:0] value);
      logic [STORE_W-1:0] data;
      logic [STORE_W-1:0] popped;
      logic [STORE_W-1:0] dequeued;
      logic [ADDR_W-1:0]  tail;
      logic               fault;
      rsp_type            due;
      data  = value[STORE_W-1:0];
      fault = 1'b0;
      case (mode)
         MODE_INSERT: begin
            if (stack_depth >= DEPTH || ring_depth >= DEPTH) begin
               // full: request dropped, nothing stored
               fault = 1'b1;
            end else begin
               tail = ring_head + ring_depth[ADDR_W-1:0];
               stack_mem[stack_depth[ADDR_W-1:0]] = data;
               stack_depth++;
               ring_mem[tail] = data;
               ring_depth++;
            end
         end
         MODE_REMOVE: begin
            if (stack_depth == 0 || ring_depth == 0) begin
               // remove on empty spoils both orders
               stack_ok = 1'b0;
               ring_ok  = 1'b0;
            end else begin
               stack_depth--;
               popped   = stack_mem[stack_depth[ADDR_W-1:0]];
               dequeued = ring_mem[ring_head];
               ring_head++;
               ring_depth--;
               if (popped != data) begin
                  stack_ok = 1'b0;
               end
               if (dequeued != data) begin
                  ring_ok = 1'b0;
               end
            end
         end
         MODE_CLEAR: begin
            stack_depth = '0;
            ring_head   = '0;
            ring_depth  = '0;
            stack_ok    = 1'b1;
            ring_ok     = 1'b1;
         end
         default: begin
            // unused mode leaves everything as it is
         end
      endcase
      due.stack_match    = stack_ok;
      due.queue_match    = ring_ok;
      due.capacity_fault = fault;
      if (stack_ok && ring_ok) begin
         due.verdict = VERDICT_BOTH;
      end else if (stack_ok) begin
         due.verdict = VERDICT_STACK;
      end else if (ring_ok) begin
         due.verdict = VERDICT_QUEUE;
      end else begin
         due.verdict = VERDICT_NEITHER;
      end
      flag_reports_due.push_back(due);
   endtask

   task automatic check_report();
      rsp_type due;
      if (flag_reports_due.size() == 0) begin
         $display("%0t: result popped with no request outstanding", $time);
         mismatch_count++;
      end else begin
         due = flag_reports_due.pop_front();
         if (rsp_stack_match !== due.stack_match) begin
            $display("%0t: stack_match expected %0b, got %0b",
                     $time, due.stack_match, rsp_stack_match);
            mismatch_count++;
         end
         if (rsp_queue_match !== due.queue_match) begin
            $display("%0t: queue_match expected %0b, got %0b",
                     $time, due.queue_match, rsp_queue_match);
            mismatch_count++;
         end
         if (rsp_verdict !== due.verdict) begin
            $display("%0t: verdict expected %0d, got %0d", $time, due.verdict, rsp_verdict);
            mismatch_count++;
         end
         if (rsp_capacity_fault !== due.capacity_fault) begin
            $display("%0t: capacity_fault expected %0b, got %0b",
                     $time, due.capacity_fault, rsp_capacity_fault);
            mismatch_count++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // request driver: a request is taken at an edge with push high and full low
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      trace_event_type next_event;
      if (reset) begin
         req_push  <= 1'b0;
         req_mode  <= MODE_CLEAR;
         req_value <= '0;
         send_wait = 0;
      end else begin
         if (req_push && !req_full) begin
            classify_request(req_mode, req_value);
            draw_gap(send_calm, send_wait);
         end
         if (req_push && req_full) begin
            // block is back-pressuring, hold the request steady
         end else if (send_wait > 0) begin
            send_wait--;
            req_push <= 1'b0;
         end else if (trace_backlog.size() != 0) begin
            next_event = trace_backlog.pop_front();
            req_mode  <= next_event.mode;
            req_value <= next_event.value;
            req_push  <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor: pops with random stalls and checks each result in order
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_report();
            draw_gap(take_calm, take_wait);
         end
         if (take_wait > 0) begin
            take_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog: any handshake on either side counts as progress
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // sequence: build the whole trace, release reset, wait for the drain
   // ------------------------------------------------------------------------
   initial begin
      logic [VALUE_W-1:0] filled[$];
      logic [VALUE_W-1:0] v;

      stack_depth    = '0;
      ring_head      = '0;
      ring_depth     = '0;
      stack_ok       = 1'b1;
      ring_ok        = 1'b1;
      mismatch_count = 0;
      random_sent    = 0;
      send_calm      = 0;
      take_calm      = 0;

      // directed part: field extremes, every mode, each special case
      add_event(MODE_CLEAR,  32'h0000_0000);
      add_event(MODE_INSERT, 32'h7FFF_FFFF);
      add_event(MODE_INSERT, 32'h8000_0000);
      add_event(MODE_INSERT, 32'h0000_0000);
      add_event(MODE_INSERT, 32'hFFFF_FFFF);
      add_event(MODE_REMOVE, 32'hFFFF_FFFF);   // stack agrees, queue does not
      add_event(MODE_UNUSED, 32'hFFFF_FFFF);   // flags reported unchanged
      add_event(MODE_REMOVE, 32'h0000_0000);
      add_event(MODE_CLEAR,  32'hFFFF_FFFF);
      add_event(MODE_INSERT, 32'd1);
      add_event(MODE_INSERT, 32'd2);
      add_event(MODE_REMOVE, 32'd1);           // queue only
      add_event(MODE_REMOVE, 32'd2);
      add_event(MODE_REMOVE, 32'd5);           // remove on empty, neither
      add_event(MODE_CLEAR,  32'h8000_0000);
      add_event(MODE_INSERT, 32'hA5A5_A5A5);
      add_event(MODE_REMOVE, 32'hA5A5_A5A5);   // both
      add_event(MODE_REMOVE, 32'h0000_0000);   // empty again
      add_event(MODE_CLEAR,  32'h7FFF_FFFF);
      add_event(MODE_INSERT, 32'd3);
      add_event(MODE_REMOVE, 32'd4);           // wrong for both orders

      // fill to capacity, overflow once, take a few from the full stores
      add_event(MODE_CLEAR, 32'd0);
      for (int i = 0; i < DEPTH; i++) begin
         v = $urandom;
         filled.push_back(v);
         add_event(MODE_INSERT, v);
      end
      add_event(MODE_INSERT, $urandom);        // insert on full, dropped
      for (int i = 0; i < 3; i++) begin
         add_event(MODE_REMOVE, filled.pop_front());
      end
      add_event(MODE_CLEAR, 32'd0);

      // random part: mostly well-formed cases, some noise
      while (random_sent < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 9) == 0) begin
            add_noise();
         end else begin
            add_case();
         end
      end

      // reset held once, then released
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all requests taken and every report back
      do begin
         @(negedge clock);
      end while (trace_backlog.size() != 0 || req_push || flag_reports_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
